@@ rtl/dfla_pkg.sv @@
package dfla_pkg;

    // Sizing
    localparam int unsigned MAX_SLOTS = 1024;
    localparam int unsigned IDX_W     = $clog2(MAX_SLOTS);
    localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int unsigned ADDR_W    = 64;
    localparam int unsigned STRIDE_W  = 13;
    localparam int unsigned ACT_W     = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned PROD_W    = IDX_W + STRIDE_W;
    localparam int unsigned DIV_STEPS = ADDR_W;
    localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

    // Commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Response status codes
    localparam logic [1:0] STS_DONE   = 2'd0;
    localparam logic [1:0] STS_EMPTY  = 2'd1;
    localparam logic [1:0] STS_REJECT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

    // Reset values
    localparam logic [ADDR_W-1:0]   BASE_RST   = '0;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(32);
    localparam logic [ACT_W-1:0]    ACTIVE_RST = ACT_W'(1024);

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ADD,
        S_DIV,
        S_PUSH,
        S_RESP
    } t_state;

    // Saturate the written slot count to the stack depth
    function automatic logic [CNT_W-1:0] eff_count(input logic [ACT_W-1:0] v);
        logic [CNT_W-1:0] res;
        if (32'(v) > 32'(MAX_SLOTS)) begin
            res = CNT_W'(MAX_SLOTS);
        end else begin
            res = CNT_W'(v);
        end
        return res;
    endfunction

endpackage

@@ rtl/dfla_req_if.sv @@
interface dfla_req_if import dfla_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ADDR_W-1:0] handle_address;

    modport source (output valid, output cmd, output handle_address, input ready);
    modport sink   (input valid, input cmd, input handle_address, output ready);
endinterface

@@ rtl/dfla_rsp_if.sv @@
interface dfla_rsp_if import dfla_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [IDX_W-1:0]  slot_index;
    logic [ADDR_W-1:0] slot_address;

    modport source (output valid, output status, output slot_index, output slot_address,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input slot_address,
                    output ready);
endinterface

@@ rtl/dfla_div.sv @@
module dfla_div import dfla_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [ADDR_W-1:0]   i_dividend,
    input  logic [STRIDE_W-1:0] i_divisor,
    output logic                o_done,
    output logic [ADDR_W-1:0]   o_quotient
);

    logic                r_busy;
    logic                r_done;
    logic [DCNT_W-1:0]   r_cnt;
    logic [STRIDE_W-1:0] r_rem;
    logic [ADDR_W-1:0]   r_quo;
    logic [STRIDE_W-1:0] r_div;

    logic [STRIDE_W:0]   rem_sh;
    logic [STRIDE_W+1:0] trial;

    // One restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        rem_sh = {r_rem, r_quo[ADDR_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_div};
    end

    // Step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DCNT_W'(1);
                if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!trial[STRIDE_W+1]) begin
                r_rem <= trial[STRIDE_W-1:0];
            end else begin
                r_rem <= rem_sh[STRIDE_W-1:0];
            end
            r_quo <= {r_quo[ADDR_W-2:0], ~trial[STRIDE_W+1]};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/descriptor_free_list_allocator_unit.sv @@
// Fixed-size slot allocator over a LIFO stack of free slot indices.
//
// Request channel i_req: cmd selects allocate or free; handle_address names
// the slot to free and is ignored on allocate. Response channel o_rsp
// returns status, slot_index and slot_address, one response per request.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) set the base
// address, the slot stride and the slot count; a count write refills the
// stack with indices 0 .. count-1, highest on top. Write it while idle.
//
// Allocate steps through stack read, index select, stride multiply, base
// add and output load; free runs the 64-step radix-2 restoring divider
// that turns the address offset into an index, then a stack push and
// the output load. An empty stack on allocate, or a zero stride or a full
// stack on free, goes straight to the output load. i_req.ready is high
// only while idle, so a request is taken once the previous response is loaded.
//
// Reset restores base 0, stride 32 and 1024 slots, and the stack reads as
// freshly filled at once: no clearing pass. A stalled response is held in
// the output register while the next request is worked on; that response
// waits until the held one has gone.
module descriptor_free_list_allocator_unit import dfla_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dfla_req_if.sink             i_req,
    dfla_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    // Control state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_depth, n_depth;
    logic [CNT_W-1:0]    r_low, n_low;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [ADDR_W-1:0]   r_base, n_base;
    logic [STRIDE_W-1:0] r_stride, n_stride;
    logic                r_out_valid, n_out_valid;

    // Working payload
    logic                r_orig, n_orig;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [1:0]          r_res_status, n_res_status;
    logic [IDX_W-1:0]    r_res_idx, n_res_idx;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic [1:0]          r_out_status, n_out_status;
    logic [IDX_W-1:0]    r_out_idx, n_out_idx;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;

    // Stack memory
    logic [IDX_W-1:0]    r_mem [MAX_SLOTS];
    logic [IDX_W-1:0]    r_rd_data;
    logic                mem_re, mem_we;
    logic [IDX_W-1:0]    mem_rd_addr, mem_wr_addr, mem_wr_data;

    // Divider
    logic                div_start, div_done;
    logic [ADDR_W-1:0]   div_quo;

    logic                out_free;
    logic [CNT_W-1:0]    depth_m1;
    logic [CNT_W-1:0]    cfg_cnt;

    dfla_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.handle_address - r_base),
        .i_divisor  (r_stride),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Sequencer: next state, stack bookkeeping and response build-up
    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_low        = r_low;
        n_count      = r_count;
        n_base       = r_base;
        n_stride     = r_stride;
        n_out_valid  = r_out_valid;
        n_orig       = r_orig;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_prod       = r_prod;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_addr   = r_res_addr;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_addr   = r_out_addr;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_rd_addr  = '0;
        mem_wr_addr  = '0;
        mem_wr_data  = '0;
        div_start    = 1'b0;
        depth_m1     = r_depth - CNT_W'(1);
        cfg_cnt      = eff_count(i_cfg_data[ACT_W-1:0]);
        out_free     = !r_out_valid || o_rsp.ready;

        // Drop the held response once taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    case (i_cfg_index)
                        CFG_BASE: begin
                            n_base = i_cfg_data;
                        end
                        CFG_STRIDE: begin
                            n_stride = i_cfg_data[STRIDE_W-1:0];
                        end
                        CFG_COUNT: begin
                            n_count = cfg_cnt;
                            n_depth = cfg_cnt;
                            n_low   = cfg_cnt;
                        end
                        default: begin
                        end
                    endcase
                end
                if (i_req.valid) begin
                    n_res_idx  = '0;
                    n_res_addr = '0;
                    if (i_req.cmd == CMD_ALLOC) begin
                        if (r_depth == '0) begin
                            n_res_status = STS_EMPTY;
                            n_state      = S_RESP;
                        end else begin
                            // Pop; entries below the low mark still hold their own index
                            mem_re      = 1'b1;
                            mem_rd_addr = depth_m1[IDX_W-1:0];
                            n_pos       = depth_m1[IDX_W-1:0];
                            n_orig      = depth_m1 < r_low;
                            n_depth     = depth_m1;
                            if (depth_m1 < r_low) begin
                                n_low = depth_m1;
                            end
                            n_state = S_READ;
                        end
                    end else begin
                        if (r_stride == '0 || r_depth >= r_count) begin
                            n_res_status = STS_REJECT;
                            n_state      = S_RESP;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                end
            end
            S_READ: begin
                n_idx   = r_orig ? r_pos : r_rd_data;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_idx) * PROD_W'(r_stride);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_res_status = STS_DONE;
                n_res_idx    = r_idx;
                n_res_addr   = r_base + ADDR_W'(r_prod);
                n_state      = S_RESP;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                // Push the index back unless it lies outside the managed range
                if (div_quo >= ADDR_W'(r_count)) begin
                    n_res_status = STS_REJECT;
                end else begin
                    mem_we       = 1'b1;
                    mem_wr_addr  = r_depth[IDX_W-1:0];
                    mem_wr_data  = div_quo[IDX_W-1:0];
                    n_depth      = r_depth + CNT_W'(1);
                    n_res_status = STS_DONE;
                    n_res_idx    = div_quo[IDX_W-1:0];
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_idx    = r_res_idx;
                    n_out_addr   = r_res_addr;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= eff_count(ACTIVE_RST);
            r_low       <= eff_count(ACTIVE_RST);
            r_count     <= eff_count(ACTIVE_RST);
            r_base      <= BASE_RST;
            r_stride    <= STRIDE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_low       <= n_low;
            r_count     <= n_count;
            r_base      <= n_base;
            r_stride    <= n_stride;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_orig       <= n_orig;
        r_pos        <= n_pos;
        r_idx        <= n_idx;
        r_prod       <= n_prod;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_addr   <= n_res_addr;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_addr   <= n_out_addr;
    end

    // Free-index stack
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_rd_addr];
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.slot_index   = r_out_idx;
    assign o_rsp.slot_address = r_out_addr;

endmodule

@@ rtl/dfla_chk.sv @@
module dfla_chk import dfla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  logic              i_rsp_valid,
    input  logic              i_rsp_ready,
    input  logic [1:0]        i_rsp_status,
    input  logic [IDX_W-1:0]  i_rsp_slot_index,
    input  logic [ADDR_W-1:0] i_rsp_slot_address
);

    // A stalled response holds its contents
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_slot_index) && $stable(i_rsp_slot_address))
        else $error("response changed while stalled");

    // Only one request in flight: ready drops after a request is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in flight");

    // Status never carries the unused code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == STS_DONE || i_rsp_status == STS_EMPTY
            || i_rsp_status == STS_REJECT))
        else $error("illegal response status");

    // Refused or rejected requests carry zero index and address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != STS_DONE
            |-> i_rsp_slot_index == '0 && i_rsp_slot_address == '0)
        else $error("failed request carries a slot");

endmodule

bind descriptor_free_list_allocator_unit dfla_chk u_dfla_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_status       (o_rsp.status),
    .i_rsp_slot_index   (o_rsp.slot_index),
    .i_rsp_slot_address (o_rsp.slot_address)
);
